### src/rclc_pkg.sv
// ----------------------------------------------------------------------------
// rclc_pkg
// Shared types and constants of the reuse-counted line cache.
// ----------------------------------------------------------------------------
`default_nettype none

package rclc_pkg;

  localparam int unsigned LinesDef   = 8;
  localparam int unsigned RowW       = 10;
  localparam int unsigned ColW       = 10;
  localparam int unsigned RowLenW    = 10;
  localparam int unsigned ReuseW     = 4;
  localparam int unsigned TagW       = 20;
  localparam int unsigned CntW       = 6;
  localparam int unsigned LineOutW   = 3;
  localparam int unsigned CfgAddrW   = 3;
  localparam int unsigned CfgDataW   = 32;

  localparam logic [RowLenW-1:0] RowLenReset = RowLenW'(16);
  localparam logic [ReuseW-1:0]  ReuseReset  = ReuseW'(3);

  // Register index, taken from paddr word bit.
  localparam logic RegRowLength = 1'b0;
  localparam logic RegReuseUnit = 1'b1;

  // Request action codes.
  localparam logic ActFill   = 1'b0;
  localparam logic ActLookup = 1'b1;

  typedef enum logic [1:0] {
    ST_IDLE,
    ST_TAG,
    ST_SEARCH,
    ST_COMMIT
  } rclc_state_e;

  typedef struct packed {
    logic load;
    logic calc;
    logic search;
    logic commit;
  } rclc_cmd_t;

  typedef struct packed {
    logic out_stall;
  } rclc_status_t;

endpackage

`default_nettype wire

### src/reuse_counted_line_cache.sv
// ----------------------------------------------------------------------------
// reuse_counted_line_cache
// Sequence: a request is loaded, then goes through tag multiply-add, parallel
//   tag compare and commit; a new request is accepted only after commit, and
//   the commit step waits while a result is not taken.
// Reset: every line free, row_length = 16, reuse_unit = 3, output empty.
// ----------------------------------------------------------------------------
`default_nettype none

module reuse_counted_line_cache import rclc_pkg::*; #(
  parameter int unsigned Lines = LinesDef
) (
  input  wire logic                clk_i,
  input  wire logic                rst_ni,
  // request channel
  input  wire logic                in_valid_i,
  output logic                     in_ready_o,
  input  wire logic                action_i,
  input  wire logic [RowW-1:0]     row_i,
  input  wire logic [ColW-1:0]     column_i,
  // result channel
  output logic                     out_valid_o,
  input  wire logic                out_ready_i,
  output logic [LineOutW-1:0]      line_o,
  output logic                     hit_o,
  output logic                     full_res_o,
  output logic                     freed_o,
  output logic [CntW-1:0]          uses_left_o,
  // configuration port
  input  wire logic                psel,
  input  wire logic                penable,
  input  wire logic                pwrite,
  input  wire logic [CfgAddrW-1:0] paddr,
  input  wire logic [CfgDataW-1:0] pwdata,
  output logic [CfgDataW-1:0]      prdata,
  output logic                     pready
);

  logic [RowLenW-1:0] row_length_q;
  logic [ReuseW-1:0]  reuse_unit_q;
  logic               cfg_wr;
  logic               cfg_idx;
  rclc_cmd_t          cmd;
  rclc_status_t       status;

  // Registers sit on word addresses; the word bit picks the register.
  assign pready  = 1'b1;
  assign cfg_idx = paddr[2];
  assign cfg_wr  = psel && penable && pwrite && pready;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      row_length_q <= RowLenReset;
      reuse_unit_q <= ReuseReset;
    end else if (cfg_wr) begin
      case (cfg_idx)
        RegRowLength: row_length_q <= pwdata[RowLenW-1:0];
        RegReuseUnit: reuse_unit_q <= pwdata[ReuseW-1:0];
        default: begin
        end
      endcase
    end
  end

  // Read back the addressed register, zero-extended.
  always_comb begin
    case (cfg_idx)
      RegRowLength: prdata = CfgDataW'(row_length_q);
      RegReuseUnit: prdata = CfgDataW'(reuse_unit_q);
      default:      prdata = '0;
    endcase
  end

  // Sequencer: steps one request through tag, search and commit.
  rclc_ctrl u_ctrl (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .in_valid_i (in_valid_i),
    .in_ready_o (in_ready_o),
    .status_i   (status),
    .cmd_o      (cmd)
  );

  // Datapath: line state, compare, result register.
  rclc_datapath #(
    .Lines (Lines)
  ) u_datapath (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .cmd_i        (cmd),
    .status_o     (status),
    .action_i     (action_i),
    .row_i        (row_i),
    .column_i     (column_i),
    .row_length_i (row_length_q),
    .reuse_unit_i (reuse_unit_q),
    .out_ready_i  (out_ready_i),
    .out_valid_o  (out_valid_o),
    .line_o       (line_o),
    .hit_o        (hit_o),
    .full_res_o   (full_res_o),
    .freed_o      (freed_o),
    .uses_left_o  (uses_left_o)
  );

endmodule

`default_nettype wire

### src/rclc_ctrl.sv
// ----------------------------------------------------------------------------
// rclc_ctrl
// Sequencer: load, tag compute, tag search, commit of one request.
// ----------------------------------------------------------------------------
`default_nettype none

module rclc_ctrl import rclc_pkg::*; (
  input  wire logic         clk_i,
  input  wire logic         rst_ni,
  input  wire logic         in_valid_i,
  output logic              in_ready_o,
  input  wire rclc_status_t status_i,
  output rclc_cmd_t         cmd_o
);

  rclc_state_e state_q, state_d;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= ST_IDLE;
    end else begin
      state_q <= state_d;
    end
  end

  always_comb begin
    state_d    = state_q;
    cmd_o      = '0;
    in_ready_o = 1'b0;
    case (state_q)
      ST_IDLE: begin
        in_ready_o = 1'b1;
        if (in_valid_i) begin
          cmd_o.load = 1'b1;
          state_d    = ST_TAG;
        end
      end
      ST_TAG: begin
        cmd_o.calc = 1'b1;
        state_d    = ST_SEARCH;
      end
      ST_SEARCH: begin
        cmd_o.search = 1'b1;
        state_d      = ST_COMMIT;
      end
      ST_COMMIT: begin
        // hold until the output register is free
        if (!status_i.out_stall) begin
          cmd_o.commit = 1'b1;
          state_d      = ST_IDLE;
        end
      end
      default: begin
        state_d = ST_IDLE;
      end
    endcase
  end

endmodule

`default_nettype wire

### src/rclc_datapath.sv
// ----------------------------------------------------------------------------
// rclc_datapath
// Line tags, use counts, free bits, tag search and the result register.
// ----------------------------------------------------------------------------
`default_nettype none

module rclc_datapath import rclc_pkg::*; #(
  parameter int unsigned Lines = LinesDef
) (
  input  wire logic               clk_i,
  input  wire logic               rst_ni,
  input  wire rclc_cmd_t          cmd_i,
  output rclc_status_t            status_o,
  input  wire logic               action_i,
  input  wire logic [RowW-1:0]    row_i,
  input  wire logic [ColW-1:0]    column_i,
  input  wire logic [RowLenW-1:0] row_length_i,
  input  wire logic [ReuseW-1:0]  reuse_unit_i,
  input  wire logic               out_ready_i,
  output logic                    out_valid_o,
  output logic [LineOutW-1:0]     line_o,
  output logic                    hit_o,
  output logic                    full_res_o,
  output logic                    freed_o,
  output logic [CntW-1:0]         uses_left_o
);

  localparam int unsigned IdxW = (Lines > 1) ? $clog2(Lines) : 1;

  logic                action_q;
  logic [RowW-1:0]     row_q;
  logic [ColW-1:0]     col_q;
  logic [TagW-1:0]     tag_q, tag_d;
  logic [CntW-1:0]     cnt_q, cnt_d;
  logic [Lines-1:0]    match_q, match_d;
  logic [TagW-1:0]     line_tag_q  [Lines];
  logic [CntW-1:0]     use_count_q [Lines];
  logic [Lines-1:0]    free_q;

  logic                out_valid_q;
  logic [LineOutW-1:0] line_q, line_d;
  logic                hit_q, hit_d;
  logic                full_q, full_d;
  logic                freed_q, freed_d;
  logic [CntW-1:0]     left_q, left_d;

  logic [TagW-1:0]     prod;
  logic [RowLenW-1:0]  last_col;
  logic                edge_col;
  logic [IdxW-1:0]     fill_sel, hit_sel, sel;
  logic [IdxW+2:0]     sel_ext;
  logic                fill_found, hit_found;
  logic [CntW-1:0]     cur_cnt, dec_cnt;
  logic                dec_zero;
  logic                fill_ok, hit_ok;

  // Tag and initial count.
  always_comb begin
    prod     = TagW'(row_q) * TagW'(row_length_i);
    tag_d    = prod + TagW'(col_q);
    last_col = row_length_i - RowLenW'(1);
    edge_col = (col_q == '0) || (col_q == last_col);
    if (edge_col) begin
      cnt_d = {1'b0, reuse_unit_i, 1'b0};
    end else begin
      cnt_d = {2'b0, reuse_unit_i} + {1'b0, reuse_unit_i, 1'b0};
    end
  end

  // Per-line tag compare.
  always_comb begin
    for (int i = 0; i < Lines; i++) begin
      match_d[i] = !free_q[i] && (line_tag_q[i] == tag_q);
    end
  end

  // Lowest free line, highest matching line.
  always_comb begin
    fill_sel   = '0;
    fill_found = 1'b0;
    hit_sel    = '0;
    hit_found  = 1'b0;
    for (int i = 0; i < Lines; i++) begin
      if (free_q[i] && !fill_found) begin
        fill_sel   = IdxW'(i);
        fill_found = 1'b1;
      end
      if (match_q[i]) begin
        hit_sel   = IdxW'(i);
        hit_found = 1'b1;
      end
    end
  end

  always_comb begin
    cur_cnt  = use_count_q[hit_sel];
    dec_cnt  = (cur_cnt != '0) ? (cur_cnt - CntW'(1)) : '0;
    dec_zero = (dec_cnt == '0);
    fill_ok  = (action_q == ActFill) && fill_found;
    hit_ok   = (action_q == ActLookup) && hit_found;
    sel      = (action_q == ActFill) ? fill_sel : hit_sel;
    sel_ext  = {3'b0, sel};

    line_d  = '0;
    hit_d   = 1'b0;
    full_d  = 1'b0;
    freed_d = 1'b0;
    left_d  = '0;
    if (action_q == ActFill) begin
      if (fill_found) begin
        line_d = sel_ext[LineOutW-1:0];
        left_d = cnt_q;
      end else begin
        full_d = 1'b1;
      end
    end else if (hit_found) begin
      line_d  = sel_ext[LineOutW-1:0];
      hit_d   = 1'b1;
      freed_d = dec_zero;
      left_d  = dec_zero ? '0 : dec_cnt;
    end
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.load) begin
      action_q <= action_i;
      row_q    <= row_i;
      col_q    <= column_i;
    end
    if (cmd_i.calc) begin
      tag_q <= tag_d;
      cnt_q <= cnt_d;
    end
    if (cmd_i.search) begin
      match_q <= match_d;
    end
    if (cmd_i.commit) begin
      line_q  <= line_d;
      hit_q   <= hit_d;
      full_q  <= full_d;
      freed_q <= freed_d;
      left_q  <= left_d;
      if (fill_ok) begin
        line_tag_q[fill_sel]  <= tag_q;
        use_count_q[fill_sel] <= cnt_q;
      end
      if (hit_ok) begin
        use_count_q[hit_sel] <= dec_cnt;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      free_q      <= '1;
      out_valid_q <= 1'b0;
    end else begin
      if (cmd_i.commit) begin
        if (fill_ok) begin
          free_q[fill_sel] <= 1'b0;
        end
        if (hit_ok && dec_zero) begin
          free_q[hit_sel] <= 1'b1;
        end
      end
      if (cmd_i.commit) begin
        out_valid_q <= 1'b1;
      end else if (out_ready_i) begin
        out_valid_q <= 1'b0;
      end
    end
  end

  assign status_o.out_stall = out_valid_q && !out_ready_i;
  assign out_valid_o = out_valid_q;
  assign line_o      = line_q;
  assign hit_o       = hit_q;
  assign full_res_o  = full_q;
  assign freed_o     = freed_q;
  assign uses_left_o = left_q;

`ifndef SYNTHESIS
  a_no_commit_on_stall: assert property (@(posedge clk_i) disable iff (!rst_ni)
    cmd_i.commit |-> !(out_valid_q && !out_ready_i))
    else $error("commit while the result register is stalled");

  a_freed_is_hit: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_valid_o && freed_o) |-> (hit_o && (uses_left_o == '0)))
    else $error("freed result without a hit or with uses left");

  a_hit_not_full: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o |-> !(hit_o && full_res_o))
    else $error("result marks both hit and full");

  a_fill_occupies: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (cmd_i.commit && fill_ok) |=> !free_q[$past(fill_sel)])
    else $error("filled line still marked free");
`endif

endmodule

`default_nettype wire
